// File: design/lrsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsr_pkg
// Shared constants and types of the line run slice rasterizer.
// ----------------------------------------------------------------------------
package lrsr_pkg;

    localparam int COORD_BITS_DEF = 6;
    localparam int QUEUE_DEPTH    = 2;

    // direction flags of a segment
    localparam int SGN_XP = 0;
    localparam int SGN_XN = 1;
    localparam int SGN_YP = 2;
    localparam int SGN_YN = 3;
    localparam int SGN_W  = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_TAIL,
        ST_FLUSH
    } walk_state_t;

endpackage

// File: design/lrsr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsr_line_if / lrsr_run_if
// Valid/ready channels for line segments in and pixel runs out.
// ----------------------------------------------------------------------------
interface lrsr_line_if
    import lrsr_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [CB-1:0] start_x;
    logic signed [CB-1:0] start_y;
    logic signed [CB-1:0] end_x;
    logic signed [CB-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lrsr_run_if
    import lrsr_pkg::*;
#(
    parameter int CB = COORD_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [CB-1:0] run_x;
    logic signed [CB-1:0] run_y;
    logic        [CB:0]   run_length;
    logic                 vertical;
    logic                 last_run;

    modport source (output valid, run_x, run_y, run_length, vertical, last_run,
                    input ready);
    modport sink   (input valid, run_x, run_y, run_length, vertical, last_run,
                    output ready);
endinterface

// File: design/line_run_slice_rasterizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_run_slice_rasterizer
// Segment in, horizontal or vertical pixel runs out, final run flagged last.
// ----------------------------------------------------------------------------
// path: the queue, then the walker; each closed run waits in the pending
//   register until the next run or the flush, then goes to the output register
// walker: takes a segment only when idle, then one DDA step per cycle unless
//   the output stalls it; a two-entry queue lets new segments queue up meanwhile
// reset: asynchronous, clears the walker state, held run, output and queue
// ----------------------------------------------------------------------------
module line_run_slice_rasterizer
    import lrsr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    lrsr_line_if.sink   line_in,
    lrsr_run_if.source  run_out
);

    localparam int CMD_W = 4 * COORD_BITS + SGN_W + 1;

    logic             push_valid, push_ready;
    logic [CMD_W-1:0] push_data;
    logic             pop_valid, pop_ready;
    logic [CMD_W-1:0] pop_data;

    lrsr_front #(
        .CB    (COORD_BITS),
        .CMD_W (CMD_W)
    ) u_front (
        .line_in    (line_in),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    lrsr_queue #(
        .W (CMD_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    lrsr_back #(
        .CB    (COORD_BITS),
        .CMD_W (CMD_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .run_out   (run_out)
    );

endmodule

// File: design/lrsr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsr_front
// Classifies a segment: deltas, direction flags, steepness, major and minor.
// ----------------------------------------------------------------------------
module lrsr_front
    import lrsr_pkg::*;
#(
    parameter int CB    = COORD_BITS_DEF,
    parameter int CMD_W = 4 * CB + SGN_W + 1
)
(
    lrsr_line_if.sink         line_in,
    output logic              push_valid,
    output logic [CMD_W-1:0]  push_data,
    input  logic              push_ready
);

    logic signed [CB:0]   ddx;
    logic signed [CB:0]   ddy;
    logic        [CB:0]   adx_w;
    logic        [CB:0]   ady_w;
    logic        [CB-1:0] adx;
    logic        [CB-1:0] ady;
    logic        [CB-1:0] major;
    logic        [CB-1:0] minor;
    logic [SGN_W-1:0]     signs;
    logic                 steep;

    always_comb
    begin
        ddx   = {line_in.end_x[CB-1], line_in.end_x}
              - {line_in.start_x[CB-1], line_in.start_x};
        ddy   = {line_in.end_y[CB-1], line_in.end_y}
              - {line_in.start_y[CB-1], line_in.start_y};
        adx_w = ddx[CB] ? -ddx : ddx;
        ady_w = ddy[CB] ? -ddy : ddy;
        // magnitudes never exceed 2^CB - 1
        adx   = adx_w[CB-1:0];
        ady   = ady_w[CB-1:0];
        signs = '0;
        signs[SGN_XP] = !ddx[CB] && (ddx != '0);
        signs[SGN_XN] = ddx[CB];
        signs[SGN_YP] = !ddy[CB] && (ddy != '0);
        signs[SGN_YN] = ddy[CB];
        steep = adx < ady;
        major = steep ? ady : adx;
        minor = steep ? adx : ady;
    end

    assign push_valid    = line_in.valid;
    assign line_in.ready = push_ready;
    assign push_data     = {steep, signs, minor, major, line_in.start_y, line_in.start_x};

endmodule

// File: design/lrsr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsr_queue
// Short command queue between the classifier and the line walker.
// ----------------------------------------------------------------------------
module lrsr_queue
    import lrsr_pkg::*;
#(
    parameter int W = 4 * COORD_BITS_DEF + SGN_W + 1
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    input  logic [W-1:0] push_data,
    output logic         push_ready,
    output logic         pop_valid,
    output logic [W-1:0] pop_data,
    input  logic         pop_ready
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [W-1:0]     entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_FULL;
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/lrsr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrsr_back
// Midpoint DDA walker: one major-axis step per cycle unless the output stalls,
// run closing, one run held back for the last flag, and the output register.
// ----------------------------------------------------------------------------
module lrsr_back
    import lrsr_pkg::*;
#(
    parameter int CB    = COORD_BITS_DEF,
    parameter int CMD_W = 4 * CB + SGN_W + 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    input  logic [CMD_W-1:0] pop_data,
    output logic             pop_ready,
    lrsr_run_if.source       run_out
);

    localparam int EW = CB + 2;
    localparam logic [CB-1:0] ONE    = CB'(1);
    localparam logic [CB-1:0] ALL1   = '1;

    // command fields
    logic signed [CB-1:0] c_sx, c_sy;
    logic        [CB-1:0] c_major, c_minor;
    logic [SGN_W-1:0]     c_signs;
    logic                 c_steep;

    walk_state_t state_reg, state_next;

    logic signed [CB-1:0] cur_x_reg, cur_y_reg, org_x_reg, org_y_reg;
    logic signed [EW-1:0] err_reg;
    logic        [CB-1:0] steps_reg, major_reg, minor_reg;
    logic [SGN_W-1:0]     signs_reg;
    logic                 steep_reg;

    logic                 pend_valid_reg;
    logic signed [CB-1:0] pend_x_reg, pend_y_reg;
    logic        [CB:0]   pend_len_reg;
    logic                 pend_vert_reg;

    logic                 out_valid_reg;
    logic signed [CB-1:0] out_x_reg, out_y_reg;
    logic        [CB:0]   out_len_reg;
    logic                 out_vert_reg, out_last_reg;

    // run closing
    logic        [CB-1:0] cur_maj, org_maj, low_maj;
    logic signed [CB:0]   diff;
    logic        [CB:0]   run_len;
    logic signed [CB-1:0] run_x, run_y;
    logic                 run_nz, moved;

    // dda step
    logic        [CB-1:0] inc_x, inc_y;
    logic signed [EW-1:0] err_sub, err_step;
    logic                 err_neg;
    logic signed [CB-1:0] step_x, step_y;

    // control
    logic produce, advance, out_free, push_mid, push_last, load;

    assign {c_steep, c_signs, c_minor, c_major, c_sy, c_sx} = pop_data;

    always_comb
    begin
        cur_maj = steep_reg ? cur_y_reg : cur_x_reg;
        org_maj = steep_reg ? org_y_reg : org_x_reg;
        diff    = {cur_maj[CB-1], cur_maj} - {org_maj[CB-1], org_maj};
        run_nz  = diff != '0;
        run_len = diff[CB] ? -diff : diff;
        // walking backward: the run starts just past the current pixel
        low_maj = diff[CB] ? cur_maj + ONE : org_maj;
        run_x   = steep_reg ? org_x_reg : low_maj;
        run_y   = steep_reg ? low_maj : org_y_reg;
        moved   = steep_reg ? (cur_x_reg != org_x_reg) : (cur_y_reg != org_y_reg);
    end

    always_comb
    begin
        inc_x    = signs_reg[SGN_XP] ? ONE : (signs_reg[SGN_XN] ? ALL1 : '0);
        inc_y    = signs_reg[SGN_YP] ? ONE : (signs_reg[SGN_YN] ? ALL1 : '0);
        err_sub  = err_reg - {2'b00, minor_reg};
        err_neg  = err_sub[EW-1];
        err_step = err_neg ? err_sub + {2'b00, major_reg} : err_sub;
        step_x   = cur_x_reg;
        step_y   = cur_y_reg;
        if (steep_reg)
        begin
            step_y = cur_y_reg + inc_y;
            if (err_neg)
            begin
                step_x = cur_x_reg + inc_x;
            end
        end
        else
        begin
            step_x = cur_x_reg + inc_x;
            if (err_neg)
            begin
                step_y = cur_y_reg + inc_y;
            end
        end
    end

    // control outputs
    always_comb
    begin
        out_free = !out_valid_reg || run_out.ready;
        produce  = 1'b0;
        advance  = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                advance = 1'b1;
            end
            ST_WALK:
            begin
                produce = moved && run_nz;
                advance = !(produce && pend_valid_reg && !out_free);
            end
            ST_TAIL:
            begin
                produce = run_nz;
                advance = !(produce && pend_valid_reg && !out_free);
            end
            ST_FLUSH:
            begin
                advance = !pend_valid_reg || out_free;
            end
            default:
            begin
                advance = 1'b1;
            end
        endcase
        pop_ready = state_reg == ST_IDLE;
        load      = pop_ready && pop_valid;
        push_mid  = produce && advance && pend_valid_reg;
        push_last = (state_reg == ST_FLUSH) && pend_valid_reg && advance;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (advance && steps_reg == '0)
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                if (advance)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (advance)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load || ((state_reg == ST_FLUSH) && advance))
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (produce && advance)
            begin
                pend_valid_reg <= 1'b1;
            end
            if (push_mid || push_last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (run_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cur_x_reg <= c_sx;
            cur_y_reg <= c_sy;
            org_x_reg <= c_sx;
            org_y_reg <= c_sy;
            err_reg   <= {2'b00, (c_major >> 1)};
            steps_reg <= c_major;
            major_reg <= c_major;
            minor_reg <= c_minor;
            signs_reg <= c_signs;
            steep_reg <= c_steep;
        end
        else if ((state_reg == ST_WALK) && advance)
        begin
            if (moved)
            begin
                org_x_reg <= cur_x_reg;
                org_y_reg <= cur_y_reg;
            end
            if (steps_reg != '0)
            begin
                steps_reg <= steps_reg - 1'b1;
                cur_x_reg <= step_x;
                cur_y_reg <= step_y;
                err_reg   <= err_step;
            end
        end

        if (produce && advance)
        begin
            pend_x_reg    <= run_x;
            pend_y_reg    <= run_y;
            pend_len_reg  <= run_len;
            pend_vert_reg <= steep_reg;
        end

        if (push_mid || push_last)
        begin
            out_x_reg    <= pend_x_reg;
            out_y_reg    <= pend_y_reg;
            out_len_reg  <= pend_len_reg;
            out_vert_reg <= pend_vert_reg;
            out_last_reg <= push_last;
        end
    end

    assign run_out.valid      = out_valid_reg;
    assign run_out.run_x      = out_x_reg;
    assign run_out.run_y      = out_y_reg;
    assign run_out.run_length = out_len_reg;
    assign run_out.vertical   = out_vert_reg;
    assign run_out.last_run   = out_last_reg;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line run slice rasterizer. Segments are sent
// over the line channel and every run is checked, field by field and in
// order, against runs predicted by a midpoint DDA walk. Both channels idle at
// random; the run side holds off for a long stretch to fill the block.
// ----------------------------------------------------------------------------
module tb_top;
    import lrsr_pkg::*;

    localparam int CB           = COORD_BITS_DEF;
    localparam int CLK_HALF     = 4;
    localparam int IDLE_PCT     = 17;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 80;
    localparam int LIMIT_CYCLES = 1000000;

    typedef struct {
        logic signed [CB-1:0] x0;
        logic signed [CB-1:0] y0;
        logic signed [CB-1:0] x1;
        logic signed [CB-1:0] y1;
    } segment_t;

    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic        [CB:0]   len;
        logic                 vert;
        logic                 last;
    } run_t;

    logic clk;
    logic rst_n;
    logic no_idle;
    int   hold_asked;
    int   mismatch_count;
    int   cycle_count;
    run_t expected_runs[$];

    lrsr_line_if #(.CB(CB)) line_bus ();
    lrsr_run_if  #(.CB(CB)) run_bus ();

    line_run_slice_rasterizer #(
        .COORD_BITS (CB)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .line_in (line_bus),
        .run_out (run_bus)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // close the span from origin up to the current point; the previous held
    // run goes out and this one is held instead
    function automatic void emit_span(input bit steep, input int cx, input int cy,
                                      input int ox, input int oy,
                                      inout bit held, inout run_t held_run);
        int len;
        int x;
        int y;
        len = steep ? cy - oy : cx - ox;
        x = ox;
        y = oy;
        if (len == 0)
            return;
        if (len < 0)
        begin
            if (steep)
                y = oy + len + 1;
            else
                x = ox + len + 1;
            len = -len;
        end
        if (held)
            expected_runs.push_back(held_run);
        held          = 1'b1;
        held_run.x    = x[CB-1:0];
        held_run.y    = y[CB-1:0];
        held_run.len  = len[CB:0];
        held_run.vert = steep;
        held_run.last = 1'b0;
    endfunction

    function automatic void predict_runs(input segment_t seg);
        int   dx;
        int   dy;
        int   adx;
        int   ady;
        int   dirx;
        int   diry;
        int   major;
        int   minor;
        int   err;
        int   cx;
        int   cy;
        int   ox;
        int   oy;
        int   steps;
        bit   steep;
        bit   moved;
        bit   held;
        run_t held_run;
        dx    = int'(seg.x1) - int'(seg.x0);
        dy    = int'(seg.y1) - int'(seg.y0);
        adx   = dx < 0 ? -dx : dx;
        ady   = dy < 0 ? -dy : dy;
        dirx  = dx > 0 ? 1 : (dx < 0 ? -1 : 0);
        diry  = dy > 0 ? 1 : (dy < 0 ? -1 : 0);
        steep = adx < ady;
        major = steep ? ady : adx;
        minor = steep ? adx : ady;
        cx    = seg.x0;
        cy    = seg.y0;
        ox    = cx;
        oy    = cy;
        err   = major >>> 1;
        steps = major;
        held  = 1'b0;
        held_run = '{default: '0};
        while (1)
        begin
            moved = steep ? (cx != ox) : (cy != oy);
            if (moved)
            begin
                emit_span(steep, cx, cy, ox, oy, held, held_run);
                ox = cx;
                oy = cy;
            end
            if (steps <= 0)
                break;
            steps--;
            if (steep)
                cy += diry;
            else
                cx += dirx;
            err -= minor;
            if (err < 0)
            begin
                err += major;
                if (steep)
                    cx += dirx;
                else
                    cy += diry;
            end
        end
        emit_span(steep, cx, cy, ox, oy, held, held_run);
        if (held)
        begin
            held_run.last = 1'b1;
            expected_runs.push_back(held_run);
        end
    endfunction

    // offer one segment and return at the edge of its transfer
    task automatic send_line(input int x0, input int y0, input int x1, input int y1);
        segment_t seg;
        seg.x0 = x0[CB-1:0];
        seg.y0 = y0[CB-1:0];
        seg.x1 = x1[CB-1:0];
        seg.y1 = y1[CB-1:0];
        if (!no_idle)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                line_bus.valid <= 1'b0;
                @(posedge clk);
            end
        end
        line_bus.valid   <= 1'b1;
        line_bus.start_x <= seg.x0;
        line_bus.start_y <= seg.y0;
        line_bus.end_x   <= seg.x1;
        line_bus.end_y   <= seg.y1;
        @(posedge clk);
        while (!line_bus.ready)
            @(posedge clk);
        predict_runs(seg);
    endtask

    task automatic send_random_line();
        int pick;
        int x0;
        int y0;
        int x1;
        int y1;
        pick = $urandom_range(99);
        x0 = $urandom_range(63);
        y0 = $urandom_range(63);
        x1 = $urandom_range(63);
        y1 = $urandom_range(63);
        if (pick < 20)
        begin
            // short segment, wraps freely at the coordinate edge
            x1 = x0 + $urandom_range(8) - 4;
            y1 = y0 + $urandom_range(8) - 4;
        end
        else if (pick < 26)
        begin
            y1 = y0;
        end
        else if (pick < 32)
        begin
            x1 = x0;
        end
        else if (pick < 38)
        begin
            // diagonal before truncation to the coordinate width, either direction
            y1 = ($urandom_range(1) != 0) ? y0 + (x1 - x0) : y0 - (x1 - x0);
        end
        else if (pick < 43)
        begin
            x1 = x0;
            y1 = y0;
        end
        send_line(x0, y0, x1, y1);
    endtask

    task automatic wait_runs_drained();
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic test_directed_lines();
        send_line(-32, -32, 31, 31);
        send_line(31, 31, -32, -32);
        send_line(-32, 0, 31, 0);
        send_line(31, 5, -32, 5);
        send_line(0, -32, 0, 31);
        send_line(-3, 31, -3, -32);
        send_line(5, 5, 5, 5);
        send_line(-32, -32, -32, -32);
        send_line(31, 31, 31, 31);
        send_line(-32, -32, -31, 31);
        send_line(-32, 31, 31, 30);
        send_line(0, 0, 1, 0);
        send_line(0, 0, 0, -1);
        send_line(0, 0, 1, 1);
        send_line(0, 0, -1, 1);
        send_line(0, 0, 20, 19);
        send_line(0, 0, 19, 20);
        send_line(0, 0, -20, -7);
        send_line(0, 0, 7, -20);
        send_line(10, -10, -10, 10);
        send_line(-1, -1, 0, -32);
        send_line(-32, 31, 31, -32);
        send_line(31, -32, -32, 31);
        send_line(2, 3, 30, -29);
    endtask

    task automatic test_random_lines(input int count);
        repeat (count) send_random_line();
    endtask

    task automatic test_no_idle_stretch(input int count);
        no_idle <= 1'b1;
        repeat (count) send_random_line();
        no_idle <= 1'b0;
    endtask

    // run side holds off while segments keep coming, so the queue fills
    task automatic test_run_backpressure(input int count);
        hold_asked <= hold_asked + 1;
        repeat (count) send_random_line();
    endtask

    task automatic test_drain_pause(input int count);
        repeat (count / 2) send_random_line();
        line_bus.valid <= 1'b0;
        wait_runs_drained();
        repeat (count - count / 2) send_random_line();
    endtask

    // run side: random ready, with a counted hold-off when asked
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        run_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                run_bus.ready <= 1'b0;
            end
            else if (hold_asked != hold_seen)
            begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
                run_bus.ready <= 1'b0;
            end
            else
            begin
                run_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        run_t want;
        if (run_bus.valid && run_bus.ready)
        begin
            if (expected_runs.size() == 0)
            begin
                report_mismatch("unexpected run at x", int'(run_bus.run_x), 0);
            end
            else
            begin
                want = expected_runs.pop_front();
                if (run_bus.run_x !== want.x)
                    report_mismatch("run_x", int'(run_bus.run_x), int'(want.x));
                if (run_bus.run_y !== want.y)
                    report_mismatch("run_y", int'(run_bus.run_y), int'(want.y));
                if (run_bus.run_length !== want.len)
                    report_mismatch("run_length", int'(run_bus.run_length), int'(want.len));
                if (run_bus.vertical !== want.vert)
                    report_mismatch("vertical", int'(run_bus.vertical), int'(want.vert));
                if (run_bus.last_run !== want.last)
                    report_mismatch("last_run", int'(run_bus.last_run), int'(want.last));
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        no_idle          = 1'b0;
        hold_asked       = 0;
        mismatch_count   = 0;
        cycle_count      = 0;
        line_bus.valid   = 1'b0;
        line_bus.start_x = '0;
        line_bus.start_y = '0;
        line_bus.end_x   = '0;
        line_bus.end_y   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_lines();
        test_random_lines(240);
        test_no_idle_stretch(60);
        test_run_backpressure(16);
        test_drain_pause(30);

        line_bus.valid <= 1'b0;
        wait_runs_drained();
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
design/lrsr_pkg.sv
design/lrsr_if.sv
design/lrsr_front.sv
design/lrsr_queue.sv
design/lrsr_back.sv
design/line_run_slice_rasterizer.sv
verif/tb_top.sv
